@@ sv/brq_pkg.sv @@
// Shared types, constants and helpers of the bytecode string-reference rewriter.
// No dependencies; every other file of the block imports this package.
package brq_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [31:0] FORMAT_TABLE = 32'h0000_03A4;
    localparam logic [7:0]  EXTRA_MASK   = 8'h9E;
    localparam logic [7:0]  VARINT_DATA  = 8'h7F;
    localparam logic [7:0]  VARINT_MORE  = 8'h80;

    // operand formats
    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_QSTR   = 2'd1;
    localparam logic [1:0] FMT_VARINT = 2'd2;
    localparam logic [1:0] FMT_OFFSET = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ZERO  = 2'd2;

    // result kinds
    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_OUT_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_STATIC_COUNT = 2'd1;
    localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd2;

    typedef struct packed {
        logic [1:0] err;
        logic       done;
        logic       send;
        logic       kind;
        logic [7:0] data;
    } t_result;

    // one accepted byte yields up to two results
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r1;
        t_result    r0;
    } t_entry;

    function automatic logic [1:0] fmt_of(input logic [7:0] op);
        logic [31:0] sh;
        sh = FORMAT_TABLE >> {op[7:4], 1'b0};
        return sh[1:0];
    endfunction

endpackage

@@ sv/brq_front.sv @@
// Front end: accepts stream bytes, parses operations, keeps the string window
// and the region counters, and produces queue entries. Depends on brq_pkg.
module brq_front import brq_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output logic        o_ready,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int WS_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (WS_W > 7) ? WS_W : 7;
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [3:0] PH_OPCODE  = 4'd0;
    localparam logic [3:0] PH_VARUINT = 4'd1;
    localparam logic [3:0] PH_OFF1    = 4'd2;
    localparam logic [3:0] PH_OFF2    = 4'd3;
    localparam logic [3:0] PH_XCOUNT  = 4'd4;
    localparam logic [3:0] PH_XCOPY   = 4'd5;
    localparam logic [3:0] PH_QVAR    = 4'd6;
    localparam logic [3:0] PH_QSTATIC = 4'd7;
    localparam logic [3:0] PH_QCHARS  = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_copy, n_copy;
    logic [7:0]  r_acc, n_acc;
    logic [6:0]  r_chars, n_chars;
    logic [15:0] r_dyn, n_dyn;
    logic [14:0] r_ec, n_ec;
    logic [14:0] r_limit, n_limit;
    logic [15:0] r_static, n_static;
    logic [5:0]  r_wsize, n_wsize;
    logic [15:0] r_win [WINDOW_MAX];
    logic [15:0] n_win [WINDOW_MAX];

    logic             accept, active;
    logic [7:0]       acc_new;
    logic [CMP_W-1:0] ws, idx;
    logic             hit, do_hit, do_new;
    logic [15:0]      hit_n, new_n;
    logic             want_code, want_idx, want_char;
    logic [7:0]       code_byte;
    logic [15:0]      idx_n, idx_v;
    logic [1:0]       idx_err;
    logic             e0, e1;
    logic [14:0]      ec_a, ec_b;
    logic [7:0]       op_now;
    logic             after_xcount;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    // idle at an opcode boundary once the region is complete: drop the byte
    assign active  = accept && !(r_phase == PH_OPCODE && r_ec >= r_limit);

    assign ws = (CMP_W'(r_wsize) > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : CMP_W'(r_wsize);
    assign acc_new = {r_acc[0], i_byte[6:0]};
    assign idx     = CMP_W'(acc_new[7:1]);
    assign hit     = idx < ws;
    assign hit_n   = hit ? r_win[idx[IDX_W-1:0]] : 16'd0;
    assign new_n   = r_static + r_dyn;
    // opcode that owns the current operand: the incoming byte at an opcode boundary
    assign op_now  = (r_phase == PH_OPCODE) ? i_byte : r_op;
    assign after_xcount = (fmt_of(op_now) != FMT_QSTR) && ((op_now & EXTRA_MASK) == 8'd0);

    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_copy    = r_copy;
        n_acc     = r_acc;
        n_chars   = r_chars;
        n_dyn     = r_dyn;
        n_limit   = r_limit;
        n_static  = r_static;
        n_wsize   = r_wsize;
        want_code = 1'b0;
        want_idx  = 1'b0;
        want_char = 1'b0;
        code_byte = i_byte;
        idx_n     = 16'd0;
        idx_err   = ERR_NONE;
        do_hit    = 1'b0;
        do_new    = 1'b0;
        if (active) begin
            case (r_phase)
                PH_OPCODE: begin
                    n_op      = i_byte;
                    want_code = 1'b1;
                    case (fmt_of(i_byte))
                        FMT_NONE:   n_phase = PH_OPCODE;
                        FMT_QSTR: begin
                            n_acc   = 8'd0;
                            n_phase = PH_QVAR;
                        end
                        FMT_VARINT: n_phase = PH_VARUINT;
                        default:    n_phase = PH_OFF1;
                    endcase
                end
                PH_VARUINT: begin
                    want_code = 1'b1;
                    if ((i_byte & VARINT_MORE) == 8'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_OFF1: begin
                    want_code = 1'b1;
                    n_phase   = PH_OFF2;
                end
                PH_OFF2: begin
                    want_code = 1'b1;
                    n_phase   = PH_OPCODE;
                end
                PH_XCOUNT: begin
                    want_code = 1'b1;
                    n_copy    = i_byte;
                    n_phase   = (i_byte != 8'd0) ? PH_XCOPY : PH_OPCODE;
                end
                PH_XCOPY: begin
                    want_code = 1'b1;
                    n_copy    = r_copy - 8'd1;
                    if (r_copy == 8'd1) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_QVAR: begin
                    n_acc = acc_new;
                    if ((i_byte & VARINT_MORE) == 8'd0) begin
                        if (acc_new == 8'd0) begin
                            n_phase = PH_QSTATIC;
                        end else if (acc_new[0]) begin
                            want_idx = 1'b1;
                            do_hit   = hit;
                            idx_n    = hit_n;
                            idx_err  = !hit ? ERR_RANGE
                                     : (hit_n == 16'd0) ? ERR_ZERO : ERR_NONE;
                            n_phase  = PH_OPCODE;
                        end else begin
                            want_idx = 1'b1;
                            do_new   = (ws != '0);
                            idx_n    = new_n;
                            idx_err  = (new_n == 16'd0) ? ERR_ZERO : ERR_NONE;
                            n_dyn    = r_dyn + 16'd1;
                            n_chars  = acc_new[7:1];
                            n_phase  = PH_QCHARS;
                        end
                    end
                end
                PH_QSTATIC: begin
                    want_idx = 1'b1;
                    idx_n    = {8'd0, i_byte};
                    idx_err  = (i_byte == 8'd0) ? ERR_ZERO : ERR_NONE;
                    n_phase  = PH_OPCODE;
                end
                PH_QCHARS: begin
                    want_char = 1'b1;
                    n_chars   = r_chars - 7'd1;
                    if (r_chars == 7'd1) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: n_phase = PH_OPCODE;
            endcase
            // an operand that ends here may still owe an extra-byte count
            if (n_phase == PH_OPCODE && (r_phase == PH_OPCODE || r_phase == PH_VARUINT
                                         || r_phase == PH_OFF2) && after_xcount) begin
                n_phase = PH_XCOUNT;
            end
        end
        // configuration writes must only arrive while the block is idle; the block itself does not enforce this
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OUT_LIMIT: begin
                    n_limit = i_cfg_data[14:0];
                    n_phase = PH_OPCODE;
                end
                CFG_STATIC_COUNT: n_static = i_cfg_data;
                CFG_WINDOW_SIZE:  n_wsize  = i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // move-to-front window update
    always_comb begin
        for (int k = 0; k < WINDOW_MAX; k++) begin
            n_win[k] = r_win[k];
        end
        if (do_hit) begin
            n_win[0] = hit_n;
            for (int k = 1; k < WINDOW_MAX; k++) begin
                if (CMP_W'(k) <= idx) begin
                    n_win[k] = r_win[k-1];
                end
            end
        end else if (do_new) begin
            n_win[0] = new_n;
            for (int k = 1; k < WINDOW_MAX; k++) begin
                if (CMP_W'(k) < ws) begin
                    n_win[k] = r_win[k-1];
                end
            end
        end
    end

    // region byte budget
    assign idx_v = idx_n - 16'd1;
    assign e0    = (want_code || want_idx) && (r_ec < r_limit);
    assign ec_a  = r_ec + {14'd0, e0};
    assign e1    = want_idx && (ec_a < r_limit);
    assign ec_b  = ec_a + {14'd0, e1};

    always_comb begin
        n_ec = ec_b;
        if (i_cfg_valid && i_cfg_index == CFG_OUT_LIMIT) begin
            n_ec = 15'd0;
        end
    end

    always_comb begin
        o_entry = '0;
        if (want_char) begin
            o_entry.cnt       = 2'd1;
            o_entry.r0.data   = i_byte;
            o_entry.r0.kind   = KIND_CHAR;
            o_entry.r0.send   = (r_chars == 7'd1);
            o_entry.r0.done   = 1'b0;
            o_entry.r0.err    = ERR_NONE;
        end else begin
            o_entry.cnt       = {1'b0, e0} + {1'b0, e1};
            o_entry.r0.data   = want_idx ? idx_v[7:0] : code_byte;
            o_entry.r0.kind   = KIND_CODE;
            o_entry.r0.send   = 1'b0;
            o_entry.r0.done   = (r_ec + 15'd1) == r_limit;
            o_entry.r0.err    = want_idx ? idx_err : ERR_NONE;
            o_entry.r1.data   = idx_v[15:8];
            o_entry.r1.kind   = KIND_CODE;
            o_entry.r1.send   = 1'b0;
            o_entry.r1.done   = (ec_a + 15'd1) == r_limit;
            o_entry.r1.err    = idx_err;
        end
    end

    assign o_push = active && (o_entry.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_op     <= 8'd0;
            r_copy   <= 8'd0;
            r_acc    <= 8'd0;
            r_chars  <= 7'd0;
            r_dyn    <= 16'd0;
            r_ec     <= 15'd0;
            r_limit  <= 15'd0;
            r_static <= 16'd0;
            r_wsize  <= 6'd0;
            for (int k = 0; k < WINDOW_MAX; k++) begin
                r_win[k] <= 16'd0;
            end
        end else begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_copy   <= n_copy;
            r_acc    <= n_acc;
            r_chars  <= n_chars;
            r_dyn    <= n_dyn;
            r_ec     <= n_ec;
            r_limit  <= n_limit;
            r_static <= n_static;
            r_wsize  <= n_wsize;
            for (int k = 0; k < WINDOW_MAX; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

@@ sv/brq_queue.sv @@
// Short entry queue between the parse front end and the output back end.
// Depends on brq_pkg for the entry type.
module brq_queue import brq_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok, pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

endmodule

@@ sv/brq_back.sv @@
// Back end: splits queue entries into single results and holds them in the
// output register until the receiver takes them. Depends on brq_pkg.
module brq_back import brq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_entry  i_entry,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;
    logic    r_sel;
    logic    load, last;

    assign load     = !r_valid || i_ready;
    assign last     = r_sel || (i_entry.cnt == 2'd1);
    assign o_pop    = load && i_valid && last;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_res <= r_sel ? i_entry.r1 : i_entry.r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_sel <= !last;
            end
        end
    end

endmodule

@@ sv/bytecode_qstr_rewriter_unit.sv @@
// Top level of the bytecode string-reference rewriter.
// Instantiates brq_front, brq_queue and brq_back; depends on brq_pkg.
//
// Usage:
//  - s_axis carries one byte of the serialised operation stream per
//    transaction. m_axis carries result items: relocated code bytes
//    (tuser kind 0) and characters of new pool strings (tuser kind 1).
//  - The configuration channel writes out_limit (index 0), the static string
//    count (index 1) and the window size (index 2). Write only while idle;
//    writing out_limit starts a new region. The channel is always ready.
//  - Path: the results of an accepted byte are written into the queue and
//    from there loaded into the output register.
//  - Throughput: one byte per cycle; a string reference emits up to two index
//    bytes, which leave the output one after the other. The output register
//    drains one result per cycle while the receiver is ready, and the four-entry
//    queue absorbs the difference; s_axis_tready drops only when that queue is full.
//  - Once a region is complete at an opcode boundary, bytes are taken and
//    dropped until out_limit is written again.
//  - Reset clears all parse state, the string window and the counters; with
//    out_limit at zero the block drops input until configured.
//  - When the receiver stalls, the output register holds its result, the
//    queue fills, and then s_axis_tready falls.
module bytecode_qstr_rewriter_unit import brq_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error, rest zero
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] string_end
    output logic        m_axis_tlast,   // region_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_entry  front_entry, queue_entry;
    t_result out_res;
    logic    push, full, queue_valid, pop;
    logic    cfg_wr;

    // accept configuration in every cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    brq_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (front_entry),
        .i_cfg_valid (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    brq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_entry (queue_entry)
    );

    brq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_entry  (queue_entry),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res),
        .i_ready  (m_axis_tready)
    );

    // pack the result fields onto the stream
    assign m_axis_tdata = {6'd0, out_res.err, out_res.data};
    assign m_axis_tuser = {out_res.send, out_res.kind};
    assign m_axis_tlast = out_res.done;

endmodule
